FILE: hw/rtl/pidc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped-integral PID core
// Word formats of the input and output channels, register indexes, sequencer
// states and the sizes of the bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Input word: one control-loop sample.
  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic        [31:0] timestamp_us;
  } in_word_t;

  // Output word: one control update.
  typedef struct packed {
    logic signed [31:0] control_out;
    logic               dt_zero;
    logic               saturated;
  } out_word_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_UPPER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_LOWER  = 3'd4;

  // Reset value of the integrator clamp (applied as +/- this value).
  localparam logic signed [31:0] SUM_LIMIT_RESET = 32'sd1000000;

  // Bit-serial multiplier: operand widths and step counts.
  localparam int unsigned MUL_OP_W   = 32;
  localparam int unsigned MUL_ACC_W  = 2 * MUL_OP_W;
  localparam int unsigned MUL_LONG   = 32;
  localparam int unsigned MUL_SHORT  = 16;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_LONG + 1);

  // Restoring divider: |error delta| << 8 needs 25 bits, divisor is dt.
  localparam int unsigned DIV_STEPS  = 25;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int unsigned DIVISOR_W  = 32;

  // Control of one multiplier lane.
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_LOAD1,
    S_MUL1,
    S_LOAD2,
    S_MUL2,
    S_PROD,
    S_MUL3,
    S_ADDD,
    S_ADDI,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pid_controller_clamped_integral_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral_core: PID controller with clamped integrator
// Forms error and elapsed time per sample, clamps the error sum, derives the
// slope with a serial divider and weights all terms with Q8.8 gains.
// ----------------------------------------------------------------------------
// The core works on one sample at a time and returns one control word per
// sample. The error and elapsed time are formed as the word is taken, and the
// S_SUM state clamps the error sum. A load and a 32-bit pass of the two-lane
// bit-serial multiplier give sum * dt and P * error. A load and a 16-bit pass
// weight the integral with its gain, and a load and a 16-bit pass do the same
// for the derivative. S_ADDD and S_ADDI add up the terms, and S_FIN shifts and
// saturates them. The slope divider runs alongside the first multiply and
// never holds up the sequence. The next sample word can be taken in the same
// cycle as the control word appears. A new sample word is taken as soon as the
// sequencer is back in idle, even while the previous control word still waits
// in the output register; a control word that is not taken holds the sequencer
// in its last state. Configuration writes are taken in any cycle and must only
// be issued while idle.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integral_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  pidc_pkg::in_word_t                    in_word,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output pidc_pkg::out_word_t                   out_word,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [31:0]                           cfg_data
);

  localparam int unsigned OW = pidc_pkg::MUL_OP_W;
  localparam int unsigned AW = pidc_pkg::MUL_ACC_W;

  pidc_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [15:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic signed [31:0] sum_upper_r, sum_lower_r;

  // Controller state carried between samples.
  logic signed [31:0] accum_r;
  logic signed [16:0] last_err_r;
  logic        [31:0] last_time_r;

  // Per-sample working registers.
  logic signed [16:0]              err_r;
  logic        [31:0]              dt_r;
  logic signed [31:0]              sum_r;
  logic                            dneg_r;
  logic        [31:0]              pmag_r;
  logic        [63:0]              prod_r;
  logic                            big_r;
  logic signed [63:0]              total_r;
  logic [pidc_pkg::MUL_CNT_W-1:0]  cnt_r;
  logic                            out_valid_r;
  pidc_pkg::out_word_t             out_word_r, result;

  // Datapath helpers.
  logic signed [32:0] sum_wide, sum_up, sum_clamped;
  logic        [16:0] err_mag;
  logic        [31:0] sum_mag;
  logic        [15:0] gp_mag, gi_mag, gd_mag;
  logic        [17:0] diff, diff_mag;
  logic               dtz, negi, pneg, dterm_neg;
  logic [pidc_pkg::DIV_STEPS-1:0] dmag, div_quo;
  logic               div_start, div_busy;
  logic        [24:0] hi_bits;

  pidc_pkg::mul_ctrl_t ctrl0, ctrl1;
  logic [OW-1:0]       a0, b0, a1, b1;
  logic [AW-1:0]       acc0, acc1;

  // Error sum, clamped to the upper limit first and then to the lower one.
  always_comb begin
    sum_wide = {accum_r[31], accum_r} + {{16{err_r[16]}}, err_r};
    sum_up   = (sum_wide > $signed({sum_upper_r[31], sum_upper_r})) ?
               {sum_upper_r[31], sum_upper_r} : sum_wide;
    sum_clamped = (sum_up < $signed({sum_lower_r[31], sum_lower_r})) ?
                  {sum_lower_r[31], sum_lower_r} : sum_up;
  end

  // Magnitudes and signs of the multiplier and divider operands.
  always_comb begin
    err_mag   = err_r[16] ? 17'(-err_r) : 17'(err_r);
    sum_mag   = sum_r[31] ? (~sum_r + 32'd1) : sum_r;
    gp_mag    = gain_prop_r[15]  ? (~gain_prop_r + 16'd1)  : gain_prop_r;
    gi_mag    = gain_integ_r[15] ? (~gain_integ_r + 16'd1) : gain_integ_r;
    gd_mag    = gain_deriv_r[15] ? (~gain_deriv_r + 16'd1) : gain_deriv_r;
    diff      = {err_r[16], err_r} - {last_err_r[16], last_err_r};
    diff_mag  = diff[17] ? (~diff + 18'd1) : diff;
    dtz       = (dt_r == '0);
    dmag      = dtz ? '0 : div_quo;
    negi      = sum_r[31] ^ gain_integ_r[15];
    pneg      = err_r[16] ^ gain_prop_r[15];
    dterm_neg = dneg_r ^ gain_deriv_r[15];
  end

  // Final shift by 8 with saturation to 32 bits.
  always_comb begin
    hi_bits = total_r[63:39];
    result.dt_zero = dtz;
    if (big_r) begin
      result.saturated   = 1'b1;
      result.control_out = negi ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if ((hi_bits == '0) || (hi_bits == '1)) begin
      result.saturated   = 1'b0;
      result.control_out = total_r[39:8];
    end else begin
      result.saturated   = 1'b1;
      result.control_out = total_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // Sequencer: next state, lane control and operand selection.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    ctrl0     = '0;
    ctrl1     = '0;
    a0        = '0;
    b0        = '0;
    a1        = '0;
    b1        = '0;
    case (state_r)
      pidc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = pidc_pkg::S_SUM;
        end
      end
      pidc_pkg::S_SUM: begin
        div_start = 1'b1;
        state_nxt = pidc_pkg::S_LOAD1;
      end
      pidc_pkg::S_LOAD1: begin
        ctrl0.load = 1'b1;
        ctrl1.load = 1'b1;
        a0 = sum_mag;
        b0 = dt_r;
        a1 = {{(OW - 17){1'b0}}, err_mag};
        b1 = {{(OW - 16){1'b0}}, gp_mag};
        state_nxt = pidc_pkg::S_MUL1;
      end
      pidc_pkg::S_MUL1: begin
        ctrl0.step = 1'b1;
        ctrl1.step = 1'b1;
        if (cnt_r == pidc_pkg::MUL_CNT_W'(1)) begin
          state_nxt = pidc_pkg::S_LOAD2;
        end
      end
      pidc_pkg::S_LOAD2: begin
        // Split |integral| into halves, both weighted by |integral gain|.
        ctrl0.load = 1'b1;
        ctrl1.load = 1'b1;
        a0 = acc0[AW-1:OW];
        b0 = {{(OW - 16){1'b0}}, gi_mag};
        a1 = acc0[OW-1:0];
        b1 = {{(OW - 16){1'b0}}, gi_mag};
        state_nxt = pidc_pkg::S_MUL2;
      end
      pidc_pkg::S_MUL2: begin
        ctrl0.step = 1'b1;
        ctrl1.step = 1'b1;
        if (cnt_r == pidc_pkg::MUL_CNT_W'(1)) begin
          state_nxt = pidc_pkg::S_PROD;
        end
      end
      pidc_pkg::S_PROD: begin
        if (!div_busy) begin
          ctrl0.load = 1'b1;
          a0 = {{(OW - pidc_pkg::DIV_STEPS){1'b0}}, dmag};
          b0 = {{(OW - 16){1'b0}}, gd_mag};
          state_nxt = pidc_pkg::S_MUL3;
        end
      end
      pidc_pkg::S_MUL3: begin
        ctrl0.step = 1'b1;
        if (cnt_r == pidc_pkg::MUL_CNT_W'(1)) begin
          state_nxt = pidc_pkg::S_ADDD;
        end
      end
      pidc_pkg::S_ADDD: begin
        state_nxt = pidc_pkg::S_ADDI;
      end
      pidc_pkg::S_ADDI: begin
        state_nxt = pidc_pkg::S_FIN;
      end
      pidc_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pidc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pidc_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers, controller state and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
      sum_upper_r  <= pidc_pkg::SUM_LIMIT_RESET;
      sum_lower_r  <= -pidc_pkg::SUM_LIMIT_RESET;
      accum_r      <= '0;
      last_err_r   <= '0;
      last_time_r  <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pidc_pkg::CFG_GAIN_PROP:  gain_prop_r  <= cfg_data[15:0];
          pidc_pkg::CFG_GAIN_INTEG: gain_integ_r <= cfg_data[15:0];
          pidc_pkg::CFG_GAIN_DERIV: gain_deriv_r <= cfg_data[15:0];
          pidc_pkg::CFG_SUM_UPPER:  sum_upper_r  <= cfg_data;
          pidc_pkg::CFG_SUM_LOWER:  sum_lower_r  <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == pidc_pkg::S_IDLE && in_valid) begin
        last_time_r <= in_word.timestamp_us;
      end
      if (state_r == pidc_pkg::S_SUM) begin
        accum_r    <= sum_clamped[31:0];
        last_err_r <= err_r;
      end
      // Step counter of the multiplier lanes.
      case (state_r)
        pidc_pkg::S_LOAD1: cnt_r <= pidc_pkg::MUL_CNT_W'(pidc_pkg::MUL_LONG);
        pidc_pkg::S_LOAD2: cnt_r <= pidc_pkg::MUL_CNT_W'(pidc_pkg::MUL_SHORT);
        pidc_pkg::S_PROD:  cnt_r <= pidc_pkg::MUL_CNT_W'(pidc_pkg::MUL_SHORT);
        pidc_pkg::S_MUL1, pidc_pkg::S_MUL2, pidc_pkg::S_MUL3: cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
      if (state_r == pidc_pkg::S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-sample datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      pidc_pkg::S_IDLE: begin
        if (in_valid) begin
          err_r <= {in_word.setpoint[15], in_word.setpoint} -
                   {in_word.measured[15], in_word.measured};
          dt_r  <= in_word.timestamp_us - last_time_r;
        end
      end
      pidc_pkg::S_SUM: begin
        sum_r  <= sum_clamped[31:0];
        dneg_r <= diff[17];
      end
      pidc_pkg::S_LOAD2: begin
        pmag_r <= acc1[31:0];
      end
      pidc_pkg::S_PROD: begin
        if (!div_busy) begin
          // Upper half of the integral product must stay below 2^30.
          big_r   <= |acc0[AW-1:30];
          prod_r  <= {acc0[31:0], 32'd0} + {16'd0, acc1[47:0]};
          total_r <= pneg ? -$signed({32'd0, pmag_r}) : $signed({32'd0, pmag_r});
        end
      end
      pidc_pkg::S_ADDD: begin
        total_r <= total_r + $signed(acc0 ^ {AW{dterm_neg}}) +
                   $signed({63'd0, dterm_neg});
      end
      pidc_pkg::S_ADDI: begin
        total_r <= total_r + $signed(prod_r ^ {64{negi}}) +
                   $signed({63'd0, negi});
      end
      pidc_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_word_r <= result;
        end
      end
      default: ;
    endcase
  end

  // Slope divider: |error delta| * 256 / dt.
  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({diff_mag[16:0], 8'd0}),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Two shift-add multiplier lanes.
  pidc_mul_lane u_lane0 (
    .clk  (clk),
    .ctrl (ctrl0),
    .a    (a0),
    .b    (b0),
    .acc  (acc0)
  );

  pidc_mul_lane u_lane1 (
    .clk  (clk),
    .ctrl (ctrl1),
    .a    (a1),
    .b    (b1),
    .acc  (acc1)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

FILE: hw/rtl/pidc_mul_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_mul_lane: one lane of the bit-serial shift-add multiplier
// Takes one multiplier bit per step, LSB first, and adds the shifted
// multiplicand into a double-width accumulator.
// ----------------------------------------------------------------------------
module pidc_mul_lane (
  input  wire                                 clk,
  input  pidc_pkg::mul_ctrl_t                 ctrl,
  input  wire  [pidc_pkg::MUL_OP_W-1:0]       a,
  input  wire  [pidc_pkg::MUL_OP_W-1:0]       b,
  output logic [pidc_pkg::MUL_ACC_W-1:0]      acc
);

  logic [pidc_pkg::MUL_ACC_W-1:0] a_r, a_nxt;
  logic [pidc_pkg::MUL_OP_W-1:0]  b_r, b_nxt;
  logic [pidc_pkg::MUL_ACC_W-1:0] acc_r, acc_nxt;

  // Load clears the sum; each step consumes one multiplier bit.
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    if (ctrl.load) begin
      a_nxt   = {{(pidc_pkg::MUL_ACC_W - pidc_pkg::MUL_OP_W){1'b0}}, a};
      b_nxt   = b;
      acc_nxt = '0;
    end else if (ctrl.step) begin
      acc_nxt = acc_r + (b_r[0] ? a_r : '0);
      a_nxt   = {a_r[pidc_pkg::MUL_ACC_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[pidc_pkg::MUL_OP_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: hw/rtl/pidc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_div: restoring divider, one quotient bit per cycle
// Divides the magnitude of the scaled error delta by the elapsed time.
// The quotient is truncated; a zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module pidc_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire  [pidc_pkg::DIV_STEPS-1:0]      dividend,
  input  wire  [pidc_pkg::DIVISOR_W-1:0]      divisor,
  output logic                                busy,
  output logic [pidc_pkg::DIV_STEPS-1:0]      quotient
);

  localparam int unsigned QW = pidc_pkg::DIV_STEPS;
  localparam int unsigned DW = pidc_pkg::DIVISOR_W;

  logic                                busy_r, busy_nxt;
  logic [pidc_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DW-1:0]                       rem_r, rem_nxt;
  logic [QW-1:0]                       quo_r, quo_nxt;
  logic [DW-1:0]                       dvs_r, dvs_nxt;
  logic [DW:0]                         partial;
  logic [DW+1:0]                       trial;

  // Shift the next dividend bit into the remainder and try a subtract.
  always_comb begin
    partial  = {rem_r, quo_r[QW-1]};
    trial    = {1'b0, partial} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = partial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pidc_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/pidc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_checker: port-level checks of the PID core
// Watches the handshakes of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module pidc_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input pidc_pkg::out_word_t            out_word
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // After a sample word is taken, in_ready stays low while the core is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("sample word taken while the previous one is in flight");

  // Reset leaves no control word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A new control word only appears while the core is busy with a sample.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("control word appeared without a sample in flight");

endmodule

bind pid_controller_clamped_integral_core pidc_checker u_pidc_checker (.*);
`default_nettype wire
